FILE: rtl/core/wtrq_pkg.sv
// Package for the wavelet tree range query unit: constants, codes and shared types.
package wtrq_pkg;

  localparam int MaxElements = 1024;
  localparam int ValueBits   = 16;
  localparam int AddrBits    = $clog2(MaxElements);
  localparam int CountBits   = AddrBits + 1;

  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_BUILD    = 3'd1,
    CMD_COUNT_EQ = 3'd2,
    CMD_KTH      = 3'd3,
    CMD_COUNT_LE = 3'd4,
    CMD_SWAP     = 3'd5
  } cmd_t;

  localparam logic CFG_RANGE_LOW  = 1'b0;
  localparam logic CFG_RANGE_HIGH = 1'b1;

  typedef struct packed {
    logic                 we;
    logic [AddrBits-1:0]  waddr;
    logic [ValueBits-1:0] wdata;
    logic                 re;
    logic [AddrBits-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic                 valid;
    logic [ValueBits-1:0] answer;
    logic                 accepted;
  } res_t;

endpackage

FILE: rtl/core/wtrq_mem.sv
// Element store: one write port and one registered read port.
module wtrq_mem (
  input  logic                           clk,
  input  wtrq_pkg::mem_req_t             req,
  output logic [wtrq_pkg::ValueBits-1:0] rdata
);

  logic [wtrq_pkg::ValueBits-1:0] mem [wtrq_pkg::MaxElements];
  logic [wtrq_pkg::ValueBits-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/wtrq_ctrl.sv
// Command sequencer: appends, build sweep, range scans, rank search and swaps.
module wtrq_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [2:0]                      req_command,
  input  logic [wtrq_pkg::ValueBits-1:0]  req_element,
  input  logic [10:0]                     req_left,
  input  logic [10:0]                     req_right,
  input  logic [wtrq_pkg::ValueBits-1:0]  req_key,
  input  logic [wtrq_pkg::ValueBits-1:0]  range_lo,
  input  logic [wtrq_pkg::ValueBits-1:0]  range_hi,
  input  logic                            cfg_write,
  output wtrq_pkg::mem_req_t              mem_req,
  input  logic [wtrq_pkg::ValueBits-1:0]  mem_rdata,
  output wtrq_pkg::res_t                  res,
  input  logic                            res_ready
);

  localparam int AB = wtrq_pkg::AddrBits;
  localparam int CB = wtrq_pkg::CountBits;
  localparam int VB = wtrq_pkg::ValueBits;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SWAPW = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [2:0]     mode_r, mode_nxt;
  logic [VB-1:0]  key_r, key_nxt;
  logic [VB-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [VB-1:0]  thr_r, thr_nxt;
  logic [CB-1:0]  cnt_r, cnt_nxt;
  logic [VB-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [AB-1:0]  ptr_r, ptr_nxt, start_r, start_nxt, end_r, end_nxt;
  logic           issuing_r, issuing_nxt;
  logic           pend_r, pend_nxt, pend_last_r, pend_last_nxt;
  logic [AB-1:0]  pend_addr_r, pend_addr_nxt;
  logic [VB-1:0]  tmp_r, tmp_nxt;
  logic [CB-1:0]  elem_cnt_r, elem_cnt_nxt;
  logic           built_r, built_nxt;
  logic [VB-1:0]  ans_r, ans_nxt;
  logic           acc_r, acc_nxt;

  logic           bok;
  logic [10:0]    lm1, span;
  logic [VB-1:0]  eff_hi, clamped, m_new, a_new, b_new;
  logic [CB-1:0]  cnt_inc;
  logic           hit;

  assign req_ready = (state_r == S_IDLE);

  always_comb begin
    eff_hi = (range_hi < range_lo) ? range_lo : range_hi;
    lm1    = req_left - 11'd1;
    span   = req_right - req_left + 11'd1;
    bok    = (req_left != 11'd0) && (req_right <= 11'(elem_cnt_r))
             && (req_left <= req_right);
    clamped = (mem_rdata < lo_r) ? lo_r : ((mem_rdata > hi_r) ? hi_r : mem_rdata);
    hit = (mode_r == wtrq_pkg::CMD_COUNT_EQ) ? (mem_rdata == key_r)
                                             : (mem_rdata <= thr_r);
    cnt_inc = cnt_r + CB'(hit);
    a_new = a_r;
    b_new = b_r;
    if (VB'(cnt_inc) >= key_r) begin
      b_new = thr_r;
    end else begin
      a_new = thr_r + VB'(1);
    end
    m_new = a_new + ((b_new - a_new) >> 1);
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    thr_nxt       = thr_r;
    cnt_nxt       = cnt_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ptr_nxt       = ptr_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    issuing_nxt   = issuing_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = 1'b0;
    pend_addr_nxt = pend_addr_r;
    tmp_nxt       = tmp_r;
    elem_cnt_nxt  = elem_cnt_r;
    built_nxt     = cfg_write ? 1'b0 : built_r;
    ans_nxt       = ans_r;
    acc_nxt       = acc_r;
    mem_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          mode_nxt  = req_command;
          key_nxt   = req_key;
          lo_nxt    = range_lo;
          hi_nxt    = eff_hi;
          thr_nxt   = req_key;
          cnt_nxt   = '0;
          ans_nxt   = '0;
          acc_nxt   = 1'b0;
          state_nxt = S_DONE;
          start_nxt = lm1[AB-1:0];
          ptr_nxt   = lm1[AB-1:0];
          end_nxt   = AB'(req_right - 11'd1);
          if (req_command == wtrq_pkg::CMD_APPEND) begin
            if (elem_cnt_r < CB'(wtrq_pkg::MaxElements)) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = elem_cnt_r[AB-1:0];
              mem_req.wdata = req_element;
              elem_cnt_nxt  = elem_cnt_r + CB'(1);
              built_nxt     = 1'b0;
              acc_nxt       = 1'b1;
            end
          end else if (req_command == wtrq_pkg::CMD_BUILD) begin
            built_nxt = 1'b1;
            acc_nxt   = 1'b1;
            if (elem_cnt_r != '0) begin
              start_nxt   = '0;
              ptr_nxt     = '0;
              end_nxt     = AB'(elem_cnt_r - CB'(1));
              issuing_nxt = 1'b1;
              state_nxt   = S_SCAN;
            end
          end else if (req_command <= wtrq_pkg::CMD_SWAP && built_r) begin
            acc_nxt = 1'b1;
            if (req_command == wtrq_pkg::CMD_COUNT_EQ) begin
              if (bok && req_key >= range_lo && req_key <= eff_hi) begin
                issuing_nxt = 1'b1;
                state_nxt   = S_SCAN;
              end
            end else if (req_command == wtrq_pkg::CMD_COUNT_LE) begin
              if (bok && req_key >= range_lo) begin
                issuing_nxt = 1'b1;
                state_nxt   = S_SCAN;
              end
            end else if (req_command == wtrq_pkg::CMD_KTH) begin
              if (bok && req_key != '0 && req_key <= VB'(span)) begin
                a_nxt = range_lo;
                b_nxt = eff_hi;
                if (range_lo == eff_hi) begin
                  ans_nxt = range_lo;
                end else begin
                  thr_nxt     = range_lo + ((eff_hi - range_lo) >> 1);
                  issuing_nxt = 1'b1;
                  state_nxt   = S_SCAN;
                end
              end
            end else begin
              if (req_left != 11'd0 && {1'b0, req_left} + 12'd1 <= {1'b0, elem_cnt_r}) begin
                end_nxt     = req_left[AB-1:0];
                issuing_nxt = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
          end
        end
      end

      S_SCAN: begin
        if (issuing_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_r;
          pend_nxt      = 1'b1;
          pend_last_nxt = (ptr_r == end_r);
          pend_addr_nxt = ptr_r;
          ptr_nxt       = ptr_r + AB'(1);
          if (ptr_r == end_r) begin
            issuing_nxt = 1'b0;
          end
        end
        if (pend_r) begin
          cnt_nxt = cnt_inc;
          if (mode_r == wtrq_pkg::CMD_BUILD) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pend_addr_r;
            mem_req.wdata = clamped;
          end else if (mode_r == wtrq_pkg::CMD_SWAP) begin
            if (!pend_last_r) begin
              tmp_nxt = mem_rdata;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = start_r;
              mem_req.wdata = mem_rdata;
            end
          end
          if (pend_last_r) begin
            priority if (mode_r == wtrq_pkg::CMD_BUILD) begin
              state_nxt = S_DONE;
            end else if (mode_r == wtrq_pkg::CMD_SWAP) begin
              state_nxt = S_SWAPW;
            end else if (mode_r == wtrq_pkg::CMD_KTH) begin
              // One step of the value bisection per full pass over the range.
              a_nxt = a_new;
              b_nxt = b_new;
              if (a_new < b_new) begin
                thr_nxt     = m_new;
                cnt_nxt     = '0;
                ptr_nxt     = start_r;
                issuing_nxt = 1'b1;
              end else begin
                ans_nxt   = a_new;
                state_nxt = S_DONE;
              end
            end else begin
              ans_nxt   = VB'(cnt_inc);
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_SWAPW: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = end_r;
        mem_req.wdata = tmp_r;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign res.valid    = (state_r == S_DONE);
  assign res.answer   = ans_r;
  assign res.accepted = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issuing_r   <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      elem_cnt_r  <= '0;
      built_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issuing_r   <= issuing_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      built_r     <= built_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    thr_r       <= thr_nxt;
    cnt_r       <= cnt_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    ptr_r       <= ptr_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    pend_addr_r <= pend_addr_nxt;
    tmp_r       <= tmp_nxt;
    ans_r       <= ans_nxt;
    acc_r       <= acc_nxt;
  end

endmodule

FILE: rtl/core/wavelet_tree_range_query_unit.sv
// Top level of the wavelet tree range query unit: range registers and result register.
//
//  channel | direction | handshake             | payload
//  in_     | request   | in_valid / in_ready   | command, element, positions, key
//  out_    | result    | out_valid / out_ready | answer, accepted
//  cfg_    | write     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Append, build of an empty store and requests that need no store read skip the scan and
// go straight to the done state. Build and the counts read the store once per element.
// The k-th search repeats that pass once per bisection step, with at most 16 steps.
// Swap reads both elements and writes them back exchanged. Reset clears the element count,
// the built flag, the sequencer state, the range registers and the output valid flag.
// A stalled receiver holds the result in the output register; the core may take the next
// request meanwhile but keeps its own result until the register frees.
module wavelet_tree_range_query_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_element,
  input  logic [10:0] in_position_left,
  input  logic [10:0] in_position_right,
  input  logic [15:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_answer,
  output logic        out_accepted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]        range_low_r, range_high_r;
  logic               cfg_write;
  logic               out_valid_r;
  logic [15:0]        out_answer_r;
  logic               out_accepted_r;
  logic               res_ready;
  wtrq_pkg::mem_req_t mem_req;
  wtrq_pkg::res_t     res;
  logic [15:0]        mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid;
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= 16'd0;
      range_high_r <= 16'hFFFF;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          wtrq_pkg::CFG_RANGE_LOW:  range_low_r  <= cfg_data;
          wtrq_pkg::CFG_RANGE_HIGH: range_high_r <= cfg_data;
          default: ;
        endcase
      end
      if (res.valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_answer_r   <= res.answer;
      out_accepted_r <= res.accepted;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_answer   = out_answer_r;
  assign out_accepted = out_accepted_r;

  wtrq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req_ready   (in_ready),
    .req_command (in_command),
    .req_element (in_element),
    .req_left    (in_position_left),
    .req_right   (in_position_right),
    .req_key     (in_key),
    .range_lo    (range_low_r),
    .range_hi    (range_high_r),
    .cfg_write   (cfg_write),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res         (res),
    .res_ready   (res_ready)
  );

  wtrq_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

FILE: test/tb_wavelet_tree_range_query_unit.sv
// Testbench for the wavelet tree range query unit: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module tb_wavelet_tree_range_query_unit;

  localparam int  CycleLimit  = 4000000;
  localparam logic [2:0] CmdSpareA = 3'd6;
  localparam logic [2:0] CmdSpareB = 3'd7;

  typedef struct {
    logic [2:0]  command;
    logic [15:0] element;
    logic [10:0] left;
    logic [10:0] right;
    logic [15:0] key;
  } request_t;

  typedef struct {
    logic [15:0] answer;
    logic        accepted;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = '0;
  logic [15:0] in_element = '0;
  logic [10:0] in_position_left = '0;
  logic [10:0] in_position_right = '0;
  logic [15:0] in_key = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_answer;
  logic        out_accepted;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = wtrq_pkg::CFG_RANGE_LOW;
  logic [15:0] cfg_data = '0;

  wavelet_tree_range_query_unit dut (.*);

  always #1 clk = ~clk;

  request_t pending_q[$];
  answer_t  answer_q[$];
  request_t driven_req;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       fail_count = 0;
  int       cycle_count = 0;

  // Predictor state.
  logic [15:0] tree_store[wtrq_pkg::MaxElements];
  int          tree_count = 0;
  bit          tree_ready = 0;
  int          range_lo = 0;
  int          range_hi = 65535;

  // Generator's view of how many elements have been stored.
  int gen_count = 0;

  function automatic int count_not_above(int l, int r, int v);
    int c = 0;
    for (int p = l; p <= r; p++) if (int'(tree_store[p-1]) <= v) c++;
    return c;
  endfunction

  task automatic predict_query(input request_t q);
    answer_t res;
    int lo, hi, l, r, k, a, b, m, c;
    logic [15:0] t;
    res.answer = '0;
    res.accepted = 1'b0;
    lo = range_lo;
    hi = (range_hi < range_lo) ? range_lo : range_hi;
    l = int'(q.left);
    r = int'(q.right);
    k = int'(q.key);
    if (q.command == wtrq_pkg::CMD_APPEND) begin
      if (tree_count < wtrq_pkg::MaxElements) begin
        tree_store[tree_count] = q.element;
        tree_count++;
        tree_ready = 0;
        res.accepted = 1'b1;
      end
    end else if (q.command == wtrq_pkg::CMD_BUILD) begin
      for (int i = 0; i < tree_count; i++) begin
        if (int'(tree_store[i]) < lo) tree_store[i] = 16'(lo);
        if (int'(tree_store[i]) > hi) tree_store[i] = 16'(hi);
      end
      tree_ready = 1;
      res.accepted = 1'b1;
    end else if (q.command <= wtrq_pkg::CMD_SWAP && tree_ready) begin
      res.accepted = 1'b1;
      if (q.command == wtrq_pkg::CMD_SWAP) begin
        if (l >= 1 && l + 1 <= tree_count) begin
          t = tree_store[l-1];
          tree_store[l-1] = tree_store[l];
          tree_store[l] = t;
        end
      end else if (l >= 1 && r <= tree_count && l <= r) begin
        if (q.command == wtrq_pkg::CMD_COUNT_EQ) begin
          if (k >= lo && k <= hi) begin
            c = 0;
            for (int p = l; p <= r; p++) if (int'(tree_store[p-1]) == k) c++;
            res.answer = 16'(c);
          end
        end else if (q.command == wtrq_pkg::CMD_COUNT_LE) begin
          if (k >= lo) res.answer = 16'(count_not_above(l, r, k));
        end else if (k >= 1 && k <= r - l + 1) begin
          a = lo;
          b = hi;
          while (a < b) begin
            m = a + (b - a) / 2;
            if (count_not_above(l, r, m) >= k) b = m;
            else a = m + 1;
          end
          res.answer = 16'(a);
        end
      end
    end
    answer_q.insert(answer_q.size(), res);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // Driver: takes the next request from the queue when the channel is free, idling at random.
  always @(posedge clk) begin
    request_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) predict_query(driven_req);
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_q.pop_front();
          driven_req <= nxt;
          in_command <= nxt.command;
          in_element <= nxt.element;
          in_position_left <= nxt.left;
          in_position_right <= nxt.right;
          in_key <= nxt.key;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and decides the receiver's stalls.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected result", int'(out_answer), -1);
        end else begin
          want = answer_q.pop_front();
          if (out_answer !== want.answer)
            report_mismatch("answer", int'(out_answer), int'(want.answer));
          if (out_accepted !== want.accepted)
            report_mismatch("accepted", int'(out_accepted), int'(want.accepted));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_request(input logic [2:0] cmd, input int elem, input int l,
                              input int r, input int k);
    request_t q;
    q.command = cmd;
    q.element = 16'(elem);
    q.left = 11'(l);
    q.right = 11'(r);
    q.key = 16'(k);
    if (cmd == wtrq_pkg::CMD_APPEND && gen_count < wtrq_pkg::MaxElements) gen_count++;
    pending_q.insert(pending_q.size(), q);
  endtask

  // A random query or swap over a short stretch of the stored elements; the key may be out of range.
  task automatic push_random_query();
    int l, r, span, k, hi, pick;
    logic [2:0] cmd;
    hi = (range_hi < range_lo) ? range_lo : range_hi;
    l = (gen_count > 0) ? $urandom_range(gen_count, 1) : 1;
    span = $urandom_range(((gen_count - l) < 40) ? gen_count - l : 40);
    r = l + span;
    pick = $urandom_range(3);
    cmd = (pick == 0) ? wtrq_pkg::CMD_COUNT_EQ : (pick == 1) ? wtrq_pkg::CMD_KTH :
          (pick == 2) ? wtrq_pkg::CMD_COUNT_LE : wtrq_pkg::CMD_SWAP;
    if (cmd == wtrq_pkg::CMD_KTH) k = $urandom_range(span + 2);
    else if ($urandom_range(3) == 0) k = $urandom_range(65535);
    else k = $urandom_range(hi, range_lo);
    push_request(cmd, $urandom_range(65535), l, r, k);
  endtask

  task automatic push_random_mix(input int n);
    int hi, pick;
    hi = (range_hi < range_lo) ? range_lo : range_hi;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        if ($urandom_range(1)) begin
          push_request(wtrq_pkg::CMD_APPEND, $urandom_range(65535), 0, 0, 0);
        end else begin
          push_request(wtrq_pkg::CMD_APPEND, $urandom_range(hi, range_lo), 0, 0, 0);
        end
      end else if (pick < 20) begin
        push_request(wtrq_pkg::CMD_BUILD, 0, 0, 0, 0);
      end else if (pick < 30) begin
        push_request(3'($urandom_range(7)), $urandom_range(65535), $urandom_range(1024),
                     $urandom_range(1024), $urandom_range(65535));
      end else begin
        push_random_query();
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() > 0 || in_valid || answer_q.size() > 0);
  endtask

  task automatic write_register(input logic idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == wtrq_pkg::CFG_RANGE_LOW) range_lo = value;
    else range_hi = value;
    tree_ready = 0;
  endtask

  initial begin
    int lo_set[6] = '{0, 100, 0, 65535, 500, 0};
    int hi_set[6] = '{65535, 200, 0, 65535, 20, 0};
    int idle_set[4] = '{0, 72, 0, 7};
    int stall_set[4] = '{0, 0, 72, 7};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: refused requests, extremes and bad bounds.
    push_request(wtrq_pkg::CMD_COUNT_EQ, 0, 1, 1, 0);
    push_request(wtrq_pkg::CMD_KTH, 0, 1, 1, 1);
    push_request(wtrq_pkg::CMD_SWAP, 0, 1, 2, 0);
    push_request(CmdSpareA, 65535, 1024, 1024, 65535);
    push_request(wtrq_pkg::CMD_APPEND, 0, 0, 0, 0);
    push_request(wtrq_pkg::CMD_APPEND, 65535, 0, 0, 0);
    push_request(wtrq_pkg::CMD_APPEND, 40000, 0, 0, 0);
    push_request(wtrq_pkg::CMD_APPEND, 7, 0, 0, 0);
    push_request(wtrq_pkg::CMD_BUILD, 0, 0, 0, 0);
    push_request(CmdSpareB, 0, 0, 0, 0);
    push_request(wtrq_pkg::CMD_COUNT_EQ, 0, 1, 4, 65535);
    push_request(wtrq_pkg::CMD_COUNT_LE, 0, 0, 4, 65535);
    push_request(wtrq_pkg::CMD_COUNT_LE, 0, 1, 5, 65535);
    push_request(wtrq_pkg::CMD_COUNT_LE, 0, 3, 2, 65535);
    push_request(wtrq_pkg::CMD_COUNT_LE, 0, 1, 4, 40000);
    push_request(wtrq_pkg::CMD_KTH, 0, 1, 4, 0);
    push_request(wtrq_pkg::CMD_KTH, 0, 1, 4, 5);
    push_request(wtrq_pkg::CMD_KTH, 0, 1, 4, 4);
    push_request(wtrq_pkg::CMD_KTH, 0, 2, 3, 1);
    push_request(wtrq_pkg::CMD_SWAP, 0, 0, 0, 0);
    push_request(wtrq_pkg::CMD_SWAP, 0, 4, 0, 0);
    push_request(wtrq_pkg::CMD_SWAP, 0, 3, 0, 0);
    push_request(wtrq_pkg::CMD_COUNT_EQ, 0, 1, 4, 7);
    push_request(wtrq_pkg::CMD_APPEND, 9, 0, 0, 0);
    push_request(wtrq_pkg::CMD_COUNT_LE, 0, 1, 5, 65535);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        repeat (10) @(posedge clk);
        if (p == 5) begin
          lo_set[p] = $urandom_range(30000);
          hi_set[p] = $urandom_range(65535, lo_set[p]);
        end
        write_register(wtrq_pkg::CFG_RANGE_LOW, lo_set[p]);
        write_register(wtrq_pkg::CFG_RANGE_HIGH, hi_set[p]);
      end
      for (int s = 0; s < 4; s++) begin
        idle_pct = idle_set[s];
        stall_pct = stall_set[s];
        push_request(wtrq_pkg::CMD_BUILD, 0, 0, 0, 0);
        push_random_mix(15);
        // Once, let everything drain before the rest of the phase goes in.
        if (p == 1 && s == 1) wait_idle();
        push_random_mix(15);
        wait_idle();
      end
    end

    // Queries and swaps across the whole stored sequence.
    idle_pct = 7;
    stall_pct = 7;
    push_request(wtrq_pkg::CMD_BUILD, 0, 0, 0, 0);
    push_request(wtrq_pkg::CMD_COUNT_LE, 0, 1, gen_count, 30000);
    push_request(wtrq_pkg::CMD_KTH, 0, 1, gen_count, gen_count / 2 + 1);
    push_request(wtrq_pkg::CMD_SWAP, 0, gen_count - 1, 0, 0);
    push_request(wtrq_pkg::CMD_SWAP, 0, gen_count, 0, 0);
    push_request(wtrq_pkg::CMD_COUNT_EQ, 0, gen_count - 1, gen_count, lo_set[5]);
    push_random_mix(20);
    wait_idle();
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: wavelet_tree_range_query_unit.f
rtl/core/wtrq_pkg.sv
rtl/core/wtrq_mem.sv
rtl/core/wtrq_ctrl.sv
rtl/core/wavelet_tree_range_query_unit.sv
test/tb_wavelet_tree_range_query_unit.sv
